/* hdl/ammc_pkg.sv */
// Shared constants, register indexes and helpers for the min/max accelerometer
// calibration block. Used by the serial divider and the top level.
// No dependencies.
package ammc_pkg;

    localparam int DATA_W           = 32;
    localparam int AXES             = 3;
    localparam int ONE_G_W          = 21;
    localparam int SUM_W            = 42;
    localparam int CNT_W            = 11;
    localparam int SAMPLES_PER_POSE = 1000;

    // Dividend of the serial divider: a 33 bit magnitude shifted by 16.
    localparam int DIV_W     = 49;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [ONE_G_W-1:0] ONE_G_RESET = ONE_G_W'(642690);
    localparam logic [DATA_W-1:0]  SCALE_ONE   = 32'h0001_0000;
    localparam logic [DATA_W-1:0]  I32_MAX     = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0]  I32_MIN     = 32'h8000_0000;

    // Configuration register indexes
    localparam logic [1:0] REG_ONE_G       = 2'd0;
    localparam logic [1:0] REG_GYRO_BIAS_X = 2'd1;
    localparam logic [1:0] REG_GYRO_BIAS_Y = 2'd2;
    localparam logic [1:0] REG_GYRO_BIAS_Z = 2'd3;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CALIB   = 1'b1;
    localparam logic KIND_MEAS  = 1'b0;
    localparam logic KIND_POSE  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } clamp_t;

    // Clamp a 34 bit signed value to the 32 bit signed range.
    function automatic clamp_t clamp34(input logic [33:0] v);
        clamp_t r;
        if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end else begin
            r.val = v[33] ? I32_MIN : I32_MAX;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

/* hdl/accel_minmax_calibrate_and_correct.sv */
// Accelerometer min/max calibration and measurement correction, top level.
// Depends on ammc_pkg and ammc_div.
//
// A measure item (s_tuser = 0) returns bias- and scale-corrected acceleration
// and bias-corrected angular rate, z negated on both, with a saturation flag.
// A calibration item (s_tuser = 1) adds its acceleration to the pose sum; the
// item that completes a pose of SAMPLES_PER_POSE items returns the pose
// average and updates the running per-axis max/min, bias and scale. Other
// calibration items return nothing. Three bit-serial dividers, one per axis,
// carry out the divisions: a measure item takes one pass, by the axis scale;
// a pose-completing item takes two, first by the sample count, then by twice
// one_g. One item is processed at a time; the result register lets the next
// item be accepted while a result still waits on m_tready.
// Configuration writes are always accepted and must only be issued when the
// block is idle.
module accel_minmax_calibrate_and_correct (
    input  logic         aclk,
    input  logic         aresetn,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
    input  logic [0:0]   s_tuser,   // opcode
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // out_acc_x/y/z, out_gyro_x/y/z
    output logic [1:0]   m_tuser,   // kind, saturated
    // Configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int DW = ammc_pkg::DATA_W;

    // State codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MLD   = 4'd1;  // start measure divisions
    localparam logic [3:0] ST_MDIV  = 4'd2;
    localparam logic [3:0] ST_ALD   = 4'd3;  // start pose average divisions
    localparam logic [3:0] ST_ADIV  = 4'd4;
    localparam logic [3:0] ST_MM    = 4'd5;  // max/min update
    localparam logic [3:0] ST_BS    = 4'd6;  // bias, start scale divisions
    localparam logic [3:0] ST_SDIV  = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;  // hand result to output register

    logic [3:0] state_reg, state_next;

    // Configuration
    logic [ammc_pkg::ONE_G_W-1:0] one_g_reg;
    logic [DW-1:0]                gbias_reg [3];

    // Calibration state
    logic [ammc_pkg::SUM_W-1:0] sum_reg [3];
    logic [ammc_pkg::CNT_W-1:0] cnt_reg;
    logic [DW-1:0]              max_reg [3];
    logic [DW-1:0]              min_reg [3];
    logic [DW-1:0]              bias_reg [3];
    logic [DW-1:0]              scale_reg [3];
    logic [DW-1:0]              avg_reg [3];

    // Per-item working registers
    logic [DW:0]   adiff_reg [3];
    logic          aneg_reg [3];
    logic          azero_reg [3];
    logic          sign_reg [3];
    logic [DW-1:0] res_reg [6];
    logic          sat_reg;
    logic          kind_reg;

    // Output register
    logic          m_valid_reg;
    logic [191:0]  m_data_reg;
    logic [1:0]    m_user_reg;

    // Divider lanes
    logic                        div_start;
    logic [ammc_pkg::DIV_W-1:0]  div_dvd [3];
    logic [DW-1:0]               div_dvs [3];
    logic                        div_done [3];
    logic [ammc_pkg::DIV_W-1:0]  div_q [3];

    logic                        in_fire;
    logic                        out_free;
    logic [ammc_pkg::CNT_W-1:0]  cnt_inc;
    logic [DW-1:0]               acc_in [3];
    logic [DW-1:0]               gyr_in [3];
    ammc_pkg::clamp_t            gclamp [3];
    logic [DW:0]                 gdiff [3];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cnt_inc   = cnt_reg + 1'b1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_in[i] = s_tdata[i*DW +: DW];
            gyr_in[i] = s_tdata[(i+3)*DW +: DW];
            gdiff[i]  = {gyr_in[i][DW-1], gyr_in[i]} - {gbias_reg[i][DW-1], gbias_reg[i]};
            // Negate the z rate after removing its bias.
            gclamp[i] = ammc_pkg::clamp34((i == 2) ? (34'd0 - {gdiff[i][DW], gdiff[i]})
                                                   : {gdiff[i][DW], gdiff[i]});
        end
    end

    // Divider operand selection
    always_comb begin
        div_start = (state_reg == ST_MLD) || (state_reg == ST_ALD) || (state_reg == ST_BS);
        for (int i = 0; i < 3; i++) begin
            logic [DW:0]                 amag;
            logic [ammc_pkg::SUM_W-1:0]  smag;
            logic [DW:0]                 diff;
            amag = adiff_reg[i][DW] ? (33'd0 - adiff_reg[i]) : adiff_reg[i];
            smag = sum_reg[i][ammc_pkg::SUM_W-1] ? (ammc_pkg::SUM_W'(0) - sum_reg[i])
                                                 : sum_reg[i];
            diff = {max_reg[i][DW-1], max_reg[i]} - {min_reg[i][DW-1], min_reg[i]};
            case (state_reg)
                ST_MLD: begin
                    div_dvd[i] = {amag, 16'd0};
                    div_dvs[i] = scale_reg[i];
                end
                ST_ALD: begin
                    div_dvd[i] = ammc_pkg::DIV_W'(smag);
                    div_dvs[i] = DW'(ammc_pkg::SAMPLES_PER_POSE);
                end
                default: begin
                    // Max minus min spans up to 33 bits; keep all of them.
                    div_dvd[i] = {diff, 16'd0};
                    div_dvs[i] = {10'd0, one_g_reg, 1'b0};
                end
            endcase
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        ammc_div u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (div_dvd[g]),
            .divisor  (div_dvs[g]),
            .done     (div_done[g]),
            .quotient (div_q[g])
        );
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser[0] == ammc_pkg::OP_MEASURE) begin
                        state_next = ST_MLD;
                    end else if (cnt_inc == ammc_pkg::CNT_W'(ammc_pkg::SAMPLES_PER_POSE)) begin
                        state_next = ST_ALD;
                    end
                end
            end
            ST_MLD:  state_next = ST_MDIV;
            ST_MDIV: if (div_done[0]) state_next = ST_FIN;
            ST_ALD:  state_next = ST_ADIV;
            ST_ADIV: if (div_done[0]) state_next = ST_MM;
            ST_MM:   state_next = ST_BS;
            ST_BS:   state_next = ST_SDIV;
            ST_SDIV: if (div_done[0]) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_g_reg <= ammc_pkg::ONE_G_RESET;
            for (int i = 0; i < 3; i++) gbias_reg[i] <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ammc_pkg::REG_ONE_G:       one_g_reg    <= cfg_data[ammc_pkg::ONE_G_W-1:0];
                ammc_pkg::REG_GYRO_BIAS_X: gbias_reg[0] <= cfg_data;
                ammc_pkg::REG_GYRO_BIAS_Y: gbias_reg[1] <= cfg_data;
                ammc_pkg::REG_GYRO_BIAS_Z: gbias_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Calibration state: pose accumulation, extremes, bias and scale
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i]   <= '0;
                max_reg[i]   <= ammc_pkg::I32_MIN;
                min_reg[i]   <= ammc_pkg::I32_MAX;
                bias_reg[i]  <= '0;
                scale_reg[i] <= ammc_pkg::SCALE_ONE;
            end
        end else begin
            if (in_fire && (s_tuser[0] == ammc_pkg::OP_CALIB)) begin
                if (cnt_inc == ammc_pkg::CNT_W'(ammc_pkg::SAMPLES_PER_POSE)) begin
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_inc;
                end
                for (int i = 0; i < 3; i++) begin
                    sum_reg[i] <= sum_reg[i] + {{(ammc_pkg::SUM_W-DW){acc_in[i][DW-1]}}, acc_in[i]};
                end
            end
            for (int i = 0; i < 3; i++) begin
                logic [DW:0] bsum;
                bsum = {max_reg[i][DW-1], max_reg[i]} + {min_reg[i][DW-1], min_reg[i]};
                // Drop the sum once the average divider has it.
                if (state_reg == ST_ALD) sum_reg[i] <= '0;
                if (state_reg == ST_MM) begin
                    if ($signed(avg_reg[i]) > $signed(max_reg[i])) max_reg[i] <= avg_reg[i];
                    if ($signed(avg_reg[i]) < $signed(min_reg[i])) min_reg[i] <= avg_reg[i];
                end
                // Halve toward zero: add one to a negative sum before the shift.
                if (state_reg == ST_BS) begin
                    bias_reg[i] <= 32'((bsum + {32'd0, bsum[DW]}) >> 1);
                end
                // Equal extremes give a zero scale even when one_g is zero.
                if ((state_reg == ST_SDIV) && div_done[0]) begin
                    if ((div_q[i] == '0) || (max_reg[i] == min_reg[i])) begin
                        scale_reg[i] <= '0;
                    end else if (|div_q[i][ammc_pkg::DIV_W-1:DW-1]) begin
                        scale_reg[i] <= ammc_pkg::I32_MAX;
                    end else begin
                        scale_reg[i] <= div_q[i][DW-1:0];
                    end
                end
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (s_tuser[0] == ammc_pkg::OP_MEASURE) begin
                kind_reg <= ammc_pkg::KIND_MEAS;
                sat_reg  <= gclamp[0].sat || gclamp[1].sat || gclamp[2].sat;
                for (int i = 0; i < 3; i++) begin
                    adiff_reg[i]  <= {acc_in[i][DW-1], acc_in[i]}
                                   - {bias_reg[i][DW-1], bias_reg[i]};
                    res_reg[i+3]  <= gclamp[i].val;
                end
            end else begin
                kind_reg <= ammc_pkg::KIND_POSE;
                sat_reg  <= 1'b0;
                for (int i = 0; i < 3; i++) res_reg[i+3] <= '0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (state_reg == ST_MLD) begin
                // Quotient sign, z negated.
                aneg_reg[i]  <= adiff_reg[i][DW] ^ (i == 2);
                azero_reg[i] <= (adiff_reg[i] == '0);
            end
            if (state_reg == ST_ALD) begin
                sign_reg[i] <= sum_reg[i][ammc_pkg::SUM_W-1];
            end
            if ((state_reg == ST_ADIV) && div_done[0]) begin
                avg_reg[i] <= sign_reg[i] ? (32'd0 - div_q[i][DW-1:0]) : div_q[i][DW-1:0];
                res_reg[i] <= sign_reg[i] ? (32'd0 - div_q[i][DW-1:0]) : div_q[i][DW-1:0];
            end
        end
        if ((state_reg == ST_MDIV) && div_done[0]) begin
            for (int i = 0; i < 3; i++) begin
                logic over;
                if (aneg_reg[i]) begin
                    over = (|div_q[i][ammc_pkg::DIV_W-1:DW])
                        || (div_q[i][DW-1] && (|div_q[i][DW-2:0]));
                end else begin
                    over = |div_q[i][ammc_pkg::DIV_W-1:DW-1];
                end
                if (azero_reg[i]) begin
                    res_reg[i] <= '0;
                end else if (over) begin
                    res_reg[i] <= aneg_reg[i] ? ammc_pkg::I32_MIN : ammc_pkg::I32_MAX;
                    sat_reg    <= 1'b1;
                end else begin
                    res_reg[i] <= aneg_reg[i] ? (32'd0 - div_q[i][DW-1:0]) : div_q[i][DW-1:0];
                end
            end
        end
    end

    // Output register: hold the result until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_FIN) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FIN) && out_free) begin
            m_data_reg <= {res_reg[5], res_reg[4], res_reg[3],
                           res_reg[2], res_reg[1], res_reg[0]};
            m_user_reg <= {sat_reg, kind_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_cnt_below_pose: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < ammc_pkg::CNT_W'(ammc_pkg::SAMPLES_PER_POSE))
        else $error("pose count reached the pose length");

    a_pose_result_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == ammc_pkg::KIND_POSE))
        |-> ((m_tdata[191:96] == '0) && !m_tuser[1]))
        else $error("pose result carries rate data or saturation");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done[0] |-> ((state_reg == ST_MDIV) || (state_reg == ST_ADIV)
                         || (state_reg == ST_SDIV)))
        else $error("divider finished outside a wait state");

    a_extremes_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BS) |-> ($signed(max_reg[0]) >= $signed(min_reg[0])))
        else $error("axis max below axis min after a pose");
`endif

endmodule

/* hdl/ammc_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ammc_pkg.
module ammc_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [ammc_pkg::DIV_W-1:0]       dividend,
    input  logic [ammc_pkg::DATA_W-1:0]      divisor,
    output logic                             done,
    output logic [ammc_pkg::DIV_W-1:0]       quotient
);

    logic [ammc_pkg::DIV_W-1:0]     dvd_reg;
    logic [ammc_pkg::DATA_W:0]      rem_reg;
    logic [ammc_pkg::DATA_W-1:0]    dvs_reg;
    logic [ammc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [ammc_pkg::DATA_W:0]      rem_sh;
    logic                           q_bit;

    always_comb begin
        rem_sh = {rem_reg[ammc_pkg::DATA_W-1:0], dvd_reg[ammc_pkg::DIV_W-1]};
        q_bit  = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == ammc_pkg::DIV_CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ammc_pkg::DIV_CNT_W'(ammc_pkg::DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ammc_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Shift the dividend out at the top, quotient bits in at the bottom.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[ammc_pkg::DIV_W-2:0], q_bit};
            rem_reg <= q_bit ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for accel_minmax_calibrate_and_correct. Depends on ammc_pkg and
// the block's RTL; drives random and directed stream traffic with idle gaps and checks
// every result against a typed row or a predictor of the correction and calibration math.
`timescale 1ns / 1ps

module tb_top;

    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam int N_POSES = 1;

    typedef struct {
        logic        kind;
        logic [31:0] val [6];
        logic        sat;
    } imu_result_t;

    typedef struct {
        logic        op;
        logic [31:0] acc [3];
        logic [31:0] gyr [3];
        bit          typed;
        imu_result_t res;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    accel_minmax_calibrate_and_correct u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the block's registers and calibration state
    longint one_g_sh;
    longint gbias_sh [3];
    longint sum_sh [3];
    int     count_sh;
    longint max_sh [3];
    longint min_sh [3];
    longint abias_sh [3];
    longint ascale_sh [3];

    imu_result_t expected_q [$];
    int errors = 0;
    int n_meas = 0;
    int n_pose = 0;
    int n_cfg = 0;
    int idle_cycles = 0;

    function automatic longint sat32(longint v, inout bit sat);
        if (v > MAXV) begin
            sat = 1'b1;
            return MAXV;
        end
        if (v < MINV) begin
            sat = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    function automatic longint correct_axis(longint raw, int ax, bit neg, inout bit sat);
        longint num;
        longint q;
        num = (raw - abias_sh[ax]) * 65536;
        if (ascale_sh[ax] == 0) begin
            // Zero scale: the quotient runs off toward the sign of the numerator
            if (num == 0) return 0;
            q = (num > 0) ? MAXV + 1 : MINV - 1;
            if (neg) q = (num > 0) ? MINV - 1 : MAXV + 1;
            return sat32(q, sat);
        end
        q = num / ascale_sh[ax];
        if (neg) q = -q;
        return sat32(q, sat);
    endfunction

    // Advance the shadow state for one accepted item; returns 1 if a result follows.
    function automatic bit predict_imu(stim_row_t it, output imu_result_t r);
        longint a [3];
        longint g [3];
        longint avg;
        longint diff;
        longint s;
        bit sat;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'($signed(it.acc[i]));
            g[i] = longint'($signed(it.gyr[i]));
        end
        if (it.op == ammc_pkg::OP_MEASURE) begin
            for (int i = 0; i < 3; i++) r.val[i] = 32'(correct_axis(a[i], i, i == 2, sat));
            r.val[3] = 32'(sat32(g[0] - gbias_sh[0], sat));
            r.val[4] = 32'(sat32(g[1] - gbias_sh[1], sat));
            r.val[5] = 32'(sat32(-(g[2] - gbias_sh[2]), sat));
            r.kind = ammc_pkg::KIND_MEAS;
            r.sat = sat;
            return 1'b1;
        end
        for (int i = 0; i < 3; i++) sum_sh[i] += a[i];
        count_sh++;
        if (count_sh < ammc_pkg::SAMPLES_PER_POSE) return 1'b0;
        r.kind = ammc_pkg::KIND_POSE;
        r.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            avg = sum_sh[i] / ammc_pkg::SAMPLES_PER_POSE;
            if (avg > max_sh[i]) max_sh[i] = avg;
            if (avg < min_sh[i]) min_sh[i] = avg;
            abias_sh[i] = (max_sh[i] + min_sh[i]) / 2;
            diff = max_sh[i] - min_sh[i];
            if (one_g_sh == 0) begin
                ascale_sh[i] = (diff > 0) ? MAXV : 0;
            end else begin
                s = (diff * 65536) / (one_g_sh * 2);
                ascale_sh[i] = (s > MAXV) ? MAXV : s;
            end
            r.val[i] = 32'(avg);
            r.val[3 + i] = '0;
            sum_sh[i] = 0;
        end
        count_sh = 0;
        return 1'b1;
    endfunction

    // Pick a 32 bit value, biased toward the edges of the range
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 50);
    endfunction

    // Drive one item on the input stream and record its expected result.
    task automatic send_imu(stim_row_t it, int gap);
        imu_result_t r;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {it.gyr[2], it.gyr[1], it.gyr[0], it.acc[2], it.acc[1], it.acc[0]};
        s_tuser = it.op;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_imu(it, r)) begin
            if (it.typed) r = it.res;
            expected_q.push_back(r);
            if (r.kind == ammc_pkg::KIND_POSE) n_pose++;
            else n_meas++;
        end
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        // Calibration items that give no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write one register; only called once the block has drained
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            ammc_pkg::REG_ONE_G: one_g_sh = longint'(data[ammc_pkg::ONE_G_W-1:0]);
            ammc_pkg::REG_GYRO_BIAS_X: gbias_sh[0] = longint'($signed(data));
            ammc_pkg::REG_GYRO_BIAS_Y: gbias_sh[1] = longint'($signed(data));
            default: gbias_sh[2] = longint'($signed(data));
        endcase
        n_cfg++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic stim_row_t rand_measure();
        stim_row_t it;
        it.op = ammc_pkg::OP_MEASURE;
        it.typed = 1'b0;
        for (int i = 0; i < 3; i++) begin
            it.acc[i] = pick32();
            it.gyr[i] = pick32();
        end
        return it;
    endfunction

    // Calibration sample for one pose: gravity on one axis plus noise, sometimes wild
    function automatic stim_row_t pose_sample(int axis, bit up, longint gval);
        stim_row_t it;
        it.op = ammc_pkg::OP_CALIB;
        it.typed = 1'b0;
        for (int i = 0; i < 3; i++) begin
            it.acc[i] = 32'(signed'($urandom_range(0, 8000)) - 4000);
            it.gyr[i] = $urandom;
        end
        it.acc[axis] = 32'((up ? gval : -gval) + longint'(signed'($urandom_range(0, 8000))) - 4000);
        if ($urandom_range(0, 49) == 0) it.acc[$urandom_range(0, 2)] = pick32();
        return it;
    endfunction

    function automatic stim_row_t mk_row(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                         logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                                         bit typed, logic [31:0] ox, logic [31:0] oy,
                                         logic [31:0] oz, logic [31:0] hx, logic [31:0] hy,
                                         logic [31:0] hz, logic sat);
        stim_row_t it;
        it.op = ammc_pkg::OP_MEASURE;
        it.acc = '{ax, ay, az};
        it.gyr = '{gx, gy, gz};
        it.typed = typed;
        it.res.kind = ammc_pkg::KIND_MEAS;
        it.res.val = '{ox, oy, oz, hx, hy, hz};
        it.res.sat = sat;
        return it;
    endfunction

    // Drive ready on the result side: bursts of acceptance broken by stalls
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready = 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    end

    // Compare every result transaction with the oldest expectation
    always @(posedge aclk) begin
        imu_result_t e;
        bit bad;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result %h user %b", m_tdata, m_tuser);
            end else begin
                e = expected_q.pop_front();
                bad = (m_tuser[0] !== e.kind) || (m_tuser[1] !== e.sat);
                for (int i = 0; i < 6; i++) if (m_tdata[32*i +: 32] !== e.val[i]) bad = 1'b1;
                if (bad) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: kind %b/%b sat %b/%b data exp %h %h %h %h %h %h got %h",
                                 e.kind, m_tuser[0], e.sat, m_tuser[1], e.val[0], e.val[1],
                                 e.val[2], e.val[3], e.val[4], e.val[5], m_tdata);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_q.size());
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        stim_row_t table_rows [$];
        longint one_g_set [6];
        longint gval;
        int axis;
        bit up;

        one_g_sh = 642690;
        count_sh = 0;
        for (int i = 0; i < 3; i++) begin
            gbias_sh[i] = 0;
            sum_sh[i] = 0;
            max_sh[i] = MINV;
            min_sh[i] = MAXV;
            abias_sh[i] = 0;
            ascale_sh[i] = 65536;
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows: unit scale and zero bias after reset give raw values, z negated
        table_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1'b0));
        table_rows.push_back(mk_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1,
                                    32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001,
                                    32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001, 1'b0));
        // Negating the most negative z overflows on both sensors
        table_rows.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                                    32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                    32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1));
        table_rows.push_back(mk_row(1, 32'hffff_ffff, 32'h0001_0000, 5, 32'hffff_fffb,
                                    32'h0001_0000, 1, 1, 32'hffff_ffff, 32'hffff_0000, 5,
                                    32'hffff_fffb, 32'hffff_0000, 1'b0));
        table_rows.push_back(mk_row(0, 0, 32'h8000_0000, 0, 0, 0, 1, 0, 0, 32'h7fff_ffff,
                                    0, 0, 0, 1'b1));
        table_rows.push_back(mk_row(0, 0, 0, 0, 0, 32'h8000_0000, 1, 0, 0, 0, 0, 0,
                                    32'h7fff_ffff, 1'b1));
        table_rows.push_back(mk_row(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678,
                                    32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a988, 0,
                                    0, 0, 0, 0, 0, 0, 1'b0));
        for (int k = 0; k < 8; k++) table_rows.push_back(rand_measure());
        foreach (table_rows[k]) send_imu(table_rows[k], pick_gap());
        drain();

        // Gyro bias extremes push the rate difference out of range
        write_reg(ammc_pkg::REG_GYRO_BIAS_X, 32'h8000_0000);
        write_reg(ammc_pkg::REG_GYRO_BIAS_Y, 32'h7fff_ffff);
        write_reg(ammc_pkg::REG_GYRO_BIAS_Z, 32'h8000_0000);
        table_rows.delete();
        table_rows.push_back(mk_row(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1,
                                    0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                    1'b1));
        table_rows.push_back(mk_row(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1,
                                    0, 0, 0, 0, 0, 0, 1'b0));
        for (int k = 0; k < 6; k++) table_rows.push_back(rand_measure());
        foreach (table_rows[k]) send_imu(table_rows[k], pick_gap());
        drain();

        // One full pose with measure items mixed in. Zero one_g and a first pose that
        // leaves max equal to min give a zero scale, which the measure items after it hit.
        one_g_set = '{0, 642690, 2097151, 1, 65536, 642690};
        for (int p = 0; p < N_POSES; p++) begin
            write_reg(ammc_pkg::REG_ONE_G, (p == 4) ? 32'($urandom) : 32'(one_g_set[p]));
            write_reg(ammc_pkg::REG_GYRO_BIAS_X, (p == 5) ? 32'h0 : pick32());
            write_reg(ammc_pkg::REG_GYRO_BIAS_Y, pick32());
            write_reg(ammc_pkg::REG_GYRO_BIAS_Z, pick32());
            axis = p % 3;
            up = p[0];
            gval = (p == 2) ? 64'sd1500000000 : 64'sd642690;
            for (int k = 0; k < ammc_pkg::SAMPLES_PER_POSE; k++) begin
                send_imu(pose_sample(axis, up, gval), ($urandom_range(0, 9) == 0) ? pick_gap() : 0);
                if ($urandom_range(0, 39) == 0) send_imu(rand_measure(), pick_gap());
            end
            for (int k = 0; k < 20; k++) send_imu(rand_measure(), pick_gap());
            drain();
        end

        $display("covered %0d measure results, %0d pose results, %0d register writes",
                 n_meas, n_pose, n_cfg);
        $display("errors: %0d", errors);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
